[design/dss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the dual servo sweep sequencer.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned PULSE_W = 12;
    localparam int unsigned STEP_W  = 8;
    localparam int unsigned HOLD_W  = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned PHASE_W = 4;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 16;

    // sweep phases
    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE      = 4'd0,
        PH_MOVE_L    = 4'd1,
        PH_HOLD_L    = 4'd2,
        PH_CENTER_A  = 4'd3,
        PH_HOLD_CA   = 4'd4,
        PH_MOVE_R    = 4'd5,
        PH_HOLD_R    = 4'd6,
        PH_CENTER_B  = 4'd7,
        PH_HOLD_CB   = 4'd8
    } t_phase;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_STEP_SIZE = 3'd0;
    localparam logic [ADDR_W-1:0] REG_HOLD_TIME = 3'd1;
    localparam logic [ADDR_W-1:0] REG_SWEEP_TOT = 3'd2;
    localparam logic [ADDR_W-1:0] REG_CENTER    = 3'd3;
    localparam logic [ADDR_W-1:0] REG_LEFT_OUT  = 3'd4;
    localparam logic [ADDR_W-1:0] REG_LEFT_IN   = 3'd5;
    localparam logic [ADDR_W-1:0] REG_RIGHT_OUT = 3'd6;
    localparam logic [ADDR_W-1:0] REG_RIGHT_IN  = 3'd7;

    typedef struct packed {
        logic [STEP_W-1:0]  step_size_us;
        logic [HOLD_W-1:0]  hold_time_ms;
        logic [COUNT_W-1:0] sweep_total;
        logic [PULSE_W-1:0] center_us;
        logic [PULSE_W-1:0] left_out_us;
        logic [PULSE_W-1:0] left_in_us;
        logic [PULSE_W-1:0] right_out_us;
        logic [PULSE_W-1:0] right_in_us;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        step_size_us: 8'd10,
        hold_time_ms: 16'd300,
        sweep_total:  8'd3,
        center_us:    12'd1500,
        left_out_us:  12'd1650,
        left_in_us:   12'd1350,
        right_out_us: 12'd1650,
        right_in_us:  12'd1350
    };

    localparam logic [PULSE_W-1:0] POS_RESET = 12'd1500;

endpackage

[design/dss_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_if
// Channel interfaces: tick input, pulse result and register write.
// ----------------------------------------------------------------------------
interface dss_in_if;
    logic                         valid;
    logic                         ready;
    logic [dss_pkg::TIME_W-1:0]   time_now_ms;
    logic                         command_seen;
    logic                         sweep_request;

    modport source (output valid, time_now_ms, command_seen, sweep_request, input ready);
    modport sink   (input valid, time_now_ms, command_seen, sweep_request, output ready);
endinterface

interface dss_out_if;
    logic                         valid;
    logic                         ready;
    logic [dss_pkg::PULSE_W-1:0]  left_pulse_us;
    logic [dss_pkg::PULSE_W-1:0]  right_pulse_us;
    logic [dss_pkg::PHASE_W-1:0]  phase_code;
    logic                         busy_res;

    modport source (output valid, left_pulse_us, right_pulse_us, phase_code, busy_res,
                    input ready);
    modport sink   (input valid, left_pulse_us, right_pulse_us, phase_code, busy_res,
                    output ready);
endinterface

interface dss_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [dss_pkg::ADDR_W-1:0]   addr;
    logic [dss_pkg::DATA_W-1:0]   data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

[design/dss_slew.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_slew
// One slew step of a pulse width toward its target, clamped at the target.
// ----------------------------------------------------------------------------
module dss_slew (
    input  logic [dss_pkg::PULSE_W-1:0] i_cur,
    input  logic [dss_pkg::PULSE_W-1:0] i_tgt,
    input  logic [dss_pkg::STEP_W-1:0]  i_step,
    output logic [dss_pkg::PULSE_W-1:0] o_nxt
);

    logic [dss_pkg::PULSE_W:0]   up_sum;
    logic [dss_pkg::PULSE_W-1:0] down_gap;
    logic [dss_pkg::PULSE_W-1:0] step_ext;

    assign step_ext = {{(dss_pkg::PULSE_W-dss_pkg::STEP_W){1'b0}}, i_step};
    assign up_sum   = {1'b0, i_cur} + {1'b0, step_ext};
    assign down_gap = i_cur - i_tgt;

    always_comb begin
        if (i_cur < i_tgt) begin
            o_nxt = (up_sum > {1'b0, i_tgt}) ? i_tgt : up_sum[dss_pkg::PULSE_W-1:0];
        end else if (i_cur > i_tgt) begin
            o_nxt = (down_gap < step_ext) ? i_tgt : (i_cur - step_ext);
        end else begin
            o_nxt = i_cur;
        end
    end

endmodule

[design/dual_servo_sweep_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_servo_sweep_sequencer
// Sweeps two servo pulse widths through left, center, right, center phases.
// ----------------------------------------------------------------------------
// Usage:
//   i_in    one transfer per control tick: millisecond time, command flag and
//           sweep request flag.
//   o_out   one transfer per input tick: both pulse widths, the phase code
//           and a busy flag, in input order.
//   i_cfg   register writes (index 0..7), always ready; write only while the
//           sequencer has no tick in flight.
// Path: a tick taken lands in the input register, is processed from there
//   and its result is held in the result register.
// Throughput: one tick per cycle while o_out is not held off; the sequencer state
//   is updated in the same cycle as the result register, so a tick can follow on every cycle.
// Reset: phase idle, both widths at 1500 us, registers at their defaults,
//   both pipeline stages empty.
// Stall: while o_out is held off the result register keeps its transfer,
//   the input register fills, and i_in.ready drops once both are full.
// ----------------------------------------------------------------------------
module dual_servo_sweep_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dss_in_if.sink      i_in,
    dss_out_if.source   o_out,
    dss_cfg_if.sink     i_cfg
);

    // configuration
    dss_pkg::t_cfg r_cfg;

    // input register
    logic                         r_in_valid;
    logic [dss_pkg::TIME_W-1:0]   r_in_time;
    logic                         r_in_cmd;
    logic                         r_in_req;

    // sequencer state
    dss_pkg::t_phase              r_phase,    n_phase;
    logic [dss_pkg::PULSE_W-1:0]  r_left_pos, n_left_pos;
    logic [dss_pkg::PULSE_W-1:0]  r_right_pos, n_right_pos;
    logic [dss_pkg::TIME_W-1:0]   r_hold_begin, n_hold_begin;
    logic [dss_pkg::COUNT_W-1:0]  r_sweeps, n_sweeps;
    logic                         r_armed, n_armed;

    // result register
    logic                         r_out_valid;
    logic [dss_pkg::PULSE_W-1:0]  r_out_left;
    logic [dss_pkg::PULSE_W-1:0]  r_out_right;
    logic [dss_pkg::PHASE_W-1:0]  r_out_phase;

    logic                         out_free;
    logic                         advance;

    dss_pkg::t_phase              trig_phase;
    logic [dss_pkg::COUNT_W-1:0]  trig_sweeps;
    logic [dss_pkg::PULSE_W-1:0]  tgt_left;
    logic [dss_pkg::PULSE_W-1:0]  tgt_right;
    logic [dss_pkg::PULSE_W-1:0]  slew_left;
    logic [dss_pkg::PULSE_W-1:0]  slew_right;
    logic [dss_pkg::TIME_W-1:0]   elapsed;
    logic                         hold_done;
    logic                         arrived;
    logic [dss_pkg::COUNT_W-1:0]  sweeps_inc;

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;
    assign i_cfg.ready = 1'b1;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= dss_pkg::CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                dss_pkg::REG_STEP_SIZE: r_cfg.step_size_us <= i_cfg.data[dss_pkg::STEP_W-1:0];
                dss_pkg::REG_HOLD_TIME: r_cfg.hold_time_ms <= i_cfg.data[dss_pkg::HOLD_W-1:0];
                dss_pkg::REG_SWEEP_TOT: r_cfg.sweep_total  <= i_cfg.data[dss_pkg::COUNT_W-1:0];
                dss_pkg::REG_CENTER:    r_cfg.center_us    <= i_cfg.data[dss_pkg::PULSE_W-1:0];
                dss_pkg::REG_LEFT_OUT:  r_cfg.left_out_us  <= i_cfg.data[dss_pkg::PULSE_W-1:0];
                dss_pkg::REG_LEFT_IN:   r_cfg.left_in_us   <= i_cfg.data[dss_pkg::PULSE_W-1:0];
                dss_pkg::REG_RIGHT_OUT: r_cfg.right_out_us <= i_cfg.data[dss_pkg::PULSE_W-1:0];
                dss_pkg::REG_RIGHT_IN:  r_cfg.right_in_us  <= i_cfg.data[dss_pkg::PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    // -------------------------------------------------------- input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_time <= i_in.time_now_ms;
            r_in_cmd  <= i_in.command_seen;
            r_in_req  <= i_in.sweep_request;
        end
    end

    // ----------------------------------------------------------- slew units
    dss_slew u_slew_left (
        .i_cur  (r_left_pos),
        .i_tgt  (tgt_left),
        .i_step (r_cfg.step_size_us),
        .o_nxt  (slew_left)
    );

    dss_slew u_slew_right (
        .i_cur  (r_right_pos),
        .i_tgt  (tgt_right),
        .i_step (r_cfg.step_size_us),
        .o_nxt  (slew_right)
    );

    assign elapsed    = r_in_time - r_hold_begin;
    assign hold_done  = elapsed >= {{(dss_pkg::TIME_W-dss_pkg::HOLD_W){1'b0}},
                                    r_cfg.hold_time_ms};
    assign arrived    = (slew_left == tgt_left) && (slew_right == tgt_right);
    assign sweeps_inc = trig_sweeps + 1'b1;

    // ---------------------------------------------------- next state logic
    always_comb begin
        // command and trigger latch first
        trig_phase  = r_phase;
        trig_sweeps = r_sweeps;
        n_armed     = r_armed;
        if (r_in_cmd) begin
            if (r_in_req) begin
                if (!r_armed) begin
                    if (r_phase == dss_pkg::PH_IDLE) begin
                        trig_sweeps = '0;
                        trig_phase  = dss_pkg::PH_MOVE_L;
                    end
                    n_armed = 1'b1;
                end
            end else begin
                n_armed = 1'b0;
            end
        end

        unique case (trig_phase)
            dss_pkg::PH_MOVE_L: begin
                tgt_left  = r_cfg.left_out_us;
                tgt_right = r_cfg.right_in_us;
            end
            dss_pkg::PH_MOVE_R: begin
                tgt_left  = r_cfg.left_in_us;
                tgt_right = r_cfg.right_out_us;
            end
            default: begin
                tgt_left  = r_cfg.center_us;
                tgt_right = r_cfg.center_us;
            end
        endcase

        n_phase      = trig_phase;
        n_sweeps     = trig_sweeps;
        n_left_pos   = r_left_pos;
        n_right_pos  = r_right_pos;
        n_hold_begin = r_hold_begin;

        unique case (trig_phase)
            dss_pkg::PH_MOVE_L, dss_pkg::PH_CENTER_A,
            dss_pkg::PH_MOVE_R, dss_pkg::PH_CENTER_B: begin
                n_left_pos  = slew_left;
                n_right_pos = slew_right;
                if (arrived) begin
                    n_hold_begin = r_in_time;
                    n_phase      = dss_pkg::t_phase'(trig_phase + 1'b1);
                end
            end
            dss_pkg::PH_HOLD_L, dss_pkg::PH_HOLD_CA, dss_pkg::PH_HOLD_R: begin
                if (hold_done) begin
                    n_phase = dss_pkg::t_phase'(trig_phase + 1'b1);
                end
            end
            dss_pkg::PH_HOLD_CB: begin
                if (hold_done) begin
                    n_sweeps = sweeps_inc;
                    n_phase  = (sweeps_inc >= r_cfg.sweep_total) ? dss_pkg::PH_IDLE
                                                                 : dss_pkg::PH_MOVE_L;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------- state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= dss_pkg::PH_IDLE;
            r_left_pos   <= dss_pkg::POS_RESET;
            r_right_pos  <= dss_pkg::POS_RESET;
            r_hold_begin <= '0;
            r_sweeps     <= '0;
            r_armed      <= 1'b0;
        end else if (advance) begin
            r_phase      <= n_phase;
            r_left_pos   <= n_left_pos;
            r_right_pos  <= n_right_pos;
            r_hold_begin <= n_hold_begin;
            r_sweeps     <= n_sweeps;
            r_armed      <= n_armed;
        end
    end

    // ------------------------------------------------------ result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_left  <= n_left_pos;
            r_out_right <= n_right_pos;
            r_out_phase <= n_phase;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.left_pulse_us  = r_out_left;
    assign o_out.right_pulse_us = r_out_right;
    assign o_out.phase_code     = r_out_phase;
    assign o_out.busy_res       = (r_out_phase != dss_pkg::PH_IDLE);

endmodule

[dv/tb_dual_servo_sweep_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_servo_sweep_sequencer
// Self-checking bench: a scripted opening (reset values, request latch,
// time wrap, hold threshold) followed by randomized command/time streams under
// several register profiles, every tick checked against scripted values or an in-bench model.
// ----------------------------------------------------------------------------
module tb_dual_servo_sweep_sequencer;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned SCRIPT_ROWS = 11;

    typedef struct packed {
        logic [dss_pkg::PULSE_W-1:0] left_us;
        logic [dss_pkg::PULSE_W-1:0] right_us;
        dss_pkg::t_phase             phase;
        logic                        busy;
    } t_pulse_res;

    typedef struct packed {
        logic [dss_pkg::TIME_W-1:0] t0;
        logic [7:0]                 reps;
        logic                       cmd;
        logic                       req;
        logic                       typed;
        t_pulse_res                 want;
    } t_row;

    localparam t_pulse_res AT_REST = '{dss_pkg::POS_RESET, dss_pkg::POS_RESET,
                                       dss_pkg::PH_IDLE, 1'b0};

    // times step by one per repeat; the left hold runs through the 32-bit wrap
    localparam t_row SCRIPT [SCRIPT_ROWS] = '{
        '{32'd0,            8'd1,  1'b0, 1'b0, 1'b1, AT_REST},
        '{32'd1,            8'd1,  1'b0, 1'b1, 1'b1, AT_REST},
        '{32'd2,            8'd1,  1'b1, 1'b0, 1'b1, AT_REST},
        '{32'hFFFF_FFF0,    8'd1,  1'b1, 1'b1, 1'b1,
          '{12'd1510, 12'd1490, dss_pkg::PH_MOVE_L, 1'b1}},
        '{32'hFFFF_FFF1,    8'd1,  1'b1, 1'b1, 1'b0, AT_REST},
        '{32'hFFFF_FFF2,    8'd1,  1'b1, 1'b0, 1'b0, AT_REST},
        '{32'hFFFF_FFF3,    8'd1,  1'b1, 1'b1, 1'b0, AT_REST},
        '{32'hFFFF_FFF4,    8'd10, 1'b0, 1'b0, 1'b0, AT_REST},
        '{32'hFFFF_FFFF,    8'd1,  1'b0, 1'b0, 1'b1,
          '{12'd1650, 12'd1350, dss_pkg::PH_HOLD_L, 1'b1}},
        '{32'd298,          8'd1,  1'b0, 1'b1, 1'b1,
          '{12'd1650, 12'd1350, dss_pkg::PH_HOLD_L, 1'b1}},
        '{32'd299,          8'd1,  1'b0, 1'b0, 1'b1,
          '{12'd1650, 12'd1350, dss_pkg::PH_CENTER_A, 1'b1}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dss_in_if  in_ch ();
    dss_out_if out_ch ();
    dss_cfg_if cfg_ch ();

    dual_servo_sweep_sequencer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // model state
    dss_pkg::t_cfg               regs_m        = dss_pkg::CFG_RESET;
    dss_pkg::t_phase             seq_phase     = dss_pkg::PH_IDLE;
    logic [dss_pkg::PULSE_W-1:0] pos_left      = dss_pkg::POS_RESET;
    logic [dss_pkg::PULSE_W-1:0] pos_right     = dss_pkg::POS_RESET;
    logic [dss_pkg::TIME_W-1:0]  hold_start    = '0;
    logic [dss_pkg::COUNT_W-1:0] sweeps_done_m = '0;
    logic                        trig_armed    = 1'b0;

    t_pulse_res                  pending_pulses[$];
    t_pulse_res                  model_out;
    t_pulse_res                  script_want   = AT_REST;
    logic                        script_typed  = 1'b0;
    int unsigned                 mismatches    = 0;
    int unsigned                 cycles        = 0;
    logic [dss_pkg::TIME_W-1:0]  clock_ms      = '0;
    logic                        in_gaps       = 1'b1;
    logic                        out_stalls    = 1'b1;
    int unsigned                 stall_left    = 0;

    function automatic logic [dss_pkg::PULSE_W-1:0] slew_toward(
            input logic [dss_pkg::PULSE_W-1:0] cur,
            input logic [dss_pkg::PULSE_W-1:0] tgt);
        logic [dss_pkg::PULSE_W:0]   sum;
        logic [dss_pkg::PULSE_W-1:0] stp;
        stp = {4'd0, regs_m.step_size_us};
        if (cur < tgt) begin
            sum = {1'b0, cur} + {1'b0, stp};
            if (sum > {1'b0, tgt}) begin
                sum = {1'b0, tgt};
            end
            return sum[dss_pkg::PULSE_W-1:0];
        end else if (cur > tgt) begin
            if ((cur - tgt) < stp) begin
                return tgt;
            end
            return cur - stp;
        end
        return cur;
    endfunction

    function automatic logic step_pair(input logic [dss_pkg::PULSE_W-1:0] tl,
                                       input logic [dss_pkg::PULSE_W-1:0] tr);
        pos_left  = slew_toward(pos_left, tl);
        pos_right = slew_toward(pos_right, tr);
        return (pos_left == tl) && (pos_right == tr);
    endfunction

    function automatic t_pulse_res advance_sequencer(input logic [dss_pkg::TIME_W-1:0] now,
                                                     input logic cmd, input logic req);
        t_pulse_res                 res;
        logic [dss_pkg::TIME_W-1:0] elapsed;
        logic                       hold_over;
        // trigger latch runs ahead of the phase update
        if (cmd) begin
            if (req) begin
                if (!trig_armed) begin
                    if (seq_phase == dss_pkg::PH_IDLE) begin
                        sweeps_done_m = '0;
                        seq_phase     = dss_pkg::PH_MOVE_L;
                    end
                    trig_armed = 1'b1;
                end
            end else begin
                trig_armed = 1'b0;
            end
        end
        elapsed   = now - hold_start;
        hold_over = elapsed >= {16'd0, regs_m.hold_time_ms};
        case (seq_phase)
            dss_pkg::PH_MOVE_L: begin
                if (step_pair(regs_m.left_out_us, regs_m.right_in_us)) begin
                    hold_start = now;
                    seq_phase  = dss_pkg::PH_HOLD_L;
                end
            end
            dss_pkg::PH_HOLD_L: if (hold_over) seq_phase = dss_pkg::PH_CENTER_A;
            dss_pkg::PH_CENTER_A: begin
                if (step_pair(regs_m.center_us, regs_m.center_us)) begin
                    hold_start = now;
                    seq_phase  = dss_pkg::PH_HOLD_CA;
                end
            end
            dss_pkg::PH_HOLD_CA: if (hold_over) seq_phase = dss_pkg::PH_MOVE_R;
            dss_pkg::PH_MOVE_R: begin
                if (step_pair(regs_m.left_in_us, regs_m.right_out_us)) begin
                    hold_start = now;
                    seq_phase  = dss_pkg::PH_HOLD_R;
                end
            end
            dss_pkg::PH_HOLD_R: if (hold_over) seq_phase = dss_pkg::PH_CENTER_B;
            dss_pkg::PH_CENTER_B: begin
                if (step_pair(regs_m.center_us, regs_m.center_us)) begin
                    hold_start = now;
                    seq_phase  = dss_pkg::PH_HOLD_CB;
                end
            end
            dss_pkg::PH_HOLD_CB: begin
                if (hold_over) begin
                    // count is compared after the increment, so a total of zero runs once
                    sweeps_done_m = sweeps_done_m + 8'd1;
                    seq_phase = (sweeps_done_m >= regs_m.sweep_total) ? dss_pkg::PH_IDLE
                                                                      : dss_pkg::PH_MOVE_L;
                end
            end
            default: ;
        endcase
        res.left_us  = pos_left;
        res.right_us = pos_right;
        res.phase    = seq_phase;
        res.busy     = (seq_phase != dss_pkg::PH_IDLE);
        return res;
    endfunction

    function automatic void take_reg_write(input logic [dss_pkg::ADDR_W-1:0] idx,
                                           input logic [dss_pkg::DATA_W-1:0] d);
        case (idx)
            dss_pkg::REG_STEP_SIZE: regs_m.step_size_us = d[dss_pkg::STEP_W-1:0];
            dss_pkg::REG_HOLD_TIME: regs_m.hold_time_ms = d[dss_pkg::HOLD_W-1:0];
            dss_pkg::REG_SWEEP_TOT: regs_m.sweep_total  = d[dss_pkg::COUNT_W-1:0];
            dss_pkg::REG_CENTER:    regs_m.center_us    = d[dss_pkg::PULSE_W-1:0];
            dss_pkg::REG_LEFT_OUT:  regs_m.left_out_us  = d[dss_pkg::PULSE_W-1:0];
            dss_pkg::REG_LEFT_IN:   regs_m.left_in_us   = d[dss_pkg::PULSE_W-1:0];
            dss_pkg::REG_RIGHT_OUT: regs_m.right_out_us = d[dss_pkg::PULSE_W-1:0];
            dss_pkg::REG_RIGHT_IN:  regs_m.right_in_us  = d[dss_pkg::PULSE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    // results are checked before the tick of the same edge is predicted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_pulses.size() == 0) begin
                    $error("result transfer with nothing expected");
                    mismatches++;
                end else begin
                    model_out = pending_pulses.pop_front();
                    check_field("left_pulse_us", 32'(model_out.left_us),
                                32'(out_ch.left_pulse_us));
                    check_field("right_pulse_us", 32'(model_out.right_us),
                                32'(out_ch.right_pulse_us));
                    check_field("phase_code", 32'(model_out.phase), 32'(out_ch.phase_code));
                    check_field("busy_res", 32'(model_out.busy), 32'(out_ch.busy_res));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                take_reg_write(cfg_ch.addr, cfg_ch.data);
            end
            if (in_ch.valid && in_ch.ready) begin
                model_out = advance_sequencer(in_ch.time_now_ms, in_ch.command_seen,
                                              in_ch.sweep_request);
                pending_pulses.push_back(script_typed ? script_want : model_out);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else if (out_stalls && $urandom_range(0, 5) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic put_tick(input logic [dss_pkg::TIME_W-1:0] t, input logic cmd,
                            input logic req);
        in_ch.valid         <= 1'b1;
        in_ch.time_now_ms   <= t;
        in_ch.command_seen  <= cmd;
        in_ch.sweep_request <= req;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        if (in_gaps && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    // sender holds off until every expected result has been seen
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_pulses.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [dss_pkg::ADDR_W-1:0] idx,
                           input logic [dss_pkg::DATA_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_profile(input logic [dss_pkg::DATA_W-1:0] stp,
                                input logic [dss_pkg::DATA_W-1:0] hold,
                                input logic [dss_pkg::DATA_W-1:0] total,
                                input logic [dss_pkg::DATA_W-1:0] ctr,
                                input logic [dss_pkg::DATA_W-1:0] lo,
                                input logic [dss_pkg::DATA_W-1:0] li,
                                input logic [dss_pkg::DATA_W-1:0] ro,
                                input logic [dss_pkg::DATA_W-1:0] ri);
        set_reg(dss_pkg::REG_STEP_SIZE, stp);
        set_reg(dss_pkg::REG_HOLD_TIME, hold);
        set_reg(dss_pkg::REG_SWEEP_TOT, total);
        set_reg(dss_pkg::REG_CENTER, ctr);
        set_reg(dss_pkg::REG_LEFT_OUT, lo);
        set_reg(dss_pkg::REG_LEFT_IN, li);
        set_reg(dss_pkg::REG_RIGHT_OUT, ro);
        set_reg(dss_pkg::REG_RIGHT_IN, ri);
    endtask

    // time mostly creeps forward at a fraction of the hold, with rare wild jumps;
    // commands randomly clear or request so the trigger latch keeps re-arming
    task automatic run_sweeps(input int unsigned n);
        int unsigned roll;
        logic        cmd;
        logic        req;
        for (int unsigned i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                clock_ms = clock_ms + $urandom;
            end else begin
                clock_ms = clock_ms + $urandom_range(0, regs_m.hold_time_ms / 8 + 3);
            end
            roll = $urandom_range(0, 99);
            cmd  = (roll < 12);
            req  = cmd ? 1'($urandom_range(0, 1)) : (roll < 30);
            put_tick(clock_ms, cmd, req);
        end
    endtask

    task automatic random_profile();
        int unsigned ctr;
        ctr = $urandom_range(400, 3600);
        load_profile(16'($urandom_range(16, 255)) | (16'($urandom) & 16'hFF00),
                     16'($urandom_range(0, 40)),
                     16'($urandom_range(0, 3)) | (16'($urandom) & 16'hFF00),
                     16'(ctr) | (16'($urandom) & 16'hF000),
                     16'(ctr + $urandom_range(0, 800) - 400),
                     16'(ctr + $urandom_range(0, 800) - 400),
                     16'(ctr + $urandom_range(0, 800) - 400),
                     16'(ctr + $urandom_range(0, 800) - 400));
    endtask

    initial begin
        in_ch.valid         = 1'b0;
        in_ch.time_now_ms   = '0;
        in_ch.command_seen  = 1'b0;
        in_ch.sweep_request = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.addr         = dss_pkg::REG_STEP_SIZE;
        cfg_ch.data         = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // opening script at reset register values
        for (int unsigned r = 0; r < SCRIPT_ROWS; r++) begin
            for (int unsigned k = 0; k < SCRIPT[r].reps; k++) begin
                script_typed = SCRIPT[r].typed;
                script_want  = SCRIPT[r].want;
                put_tick(SCRIPT[r].t0 + k, SCRIPT[r].cmd, SCRIPT[r].req);
            end
        end
        script_typed = 1'b0;
        clock_ms     = 32'd300;
        put_tick(clock_ms, 1'b0, 1'b0);
        drain_results();

        // widest swing, largest step, no dwell, single sweep
        load_profile(16'd255, 16'd0, 16'd1, 16'd4095, 16'd0, 16'd4095, 16'd0, 16'd4095);
        run_sweeps(80);
        drain_results();

        // smallest nonzero step, longest dwell, max count; junk above the field width in most writes
        load_profile(16'hFF01, 16'hFFFF, 16'hFFFF, 16'hF000, 16'hF005, 16'h0000,
                     16'hA007, 16'h5000);
        run_sweeps(60);
        drain_results();

        // zero step stalls a move, then new step and targets land mid-sweep
        set_reg(dss_pkg::REG_STEP_SIZE, 16'h0000);
        set_reg(dss_pkg::REG_HOLD_TIME, 16'd3);
        run_sweeps(30);
        drain_results();
        set_reg(dss_pkg::REG_STEP_SIZE, 16'd3);
        set_reg(dss_pkg::REG_LEFT_OUT, 16'd12);
        set_reg(dss_pkg::REG_RIGHT_IN, 16'd9);
        run_sweeps(60);
        drain_results();

        // zero sweep total still runs one sweep
        load_profile(16'd200, 16'd2, 16'd0, 16'd2048, 16'd3000, 16'd1000, 16'd3000, 16'd1000);
        run_sweeps(60);
        drain_results();

        for (int p = 0; p < 4; p++) begin
            in_gaps    = (p != 1);
            out_stalls = (p != 2);
            random_profile();
            run_sweeps(50);
            drain_results();
        end

        // closing stretch at full rate
        in_gaps    = 1'b0;
        out_stalls = 1'b0;
        random_profile();
        run_sweeps(60);
        drain_results();
        repeat (8) @(negedge i_clk);

        if (pending_pulses.size() != 0) begin
            $error("%0d expected results never arrived", pending_pulses.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
